>>> hdl/ecmp_fhs_pkg.sv
// ----------------------------------------------------------------------------
// ecmp_fhs_pkg
// Shared constants, types and mixing functions for the ECMP flow hash select.
// ----------------------------------------------------------------------------
package ecmp_fhs_pkg;

  localparam int unsigned MAX_NEXT_HOPS = 16;

  localparam int unsigned HASH_W     = 32;
  localparam int unsigned PORT_W     = 16;
  localparam int unsigned HOP_CNT_W  = 5;
  localparam int unsigned HOP_IDX_W  = 4;
  // divisor holds 0 .. MAX_NEXT_HOPS
  localparam int unsigned DIV_W      = $clog2(MAX_NEXT_HOPS + 1);
  // remainder bits retired per stage
  localparam int unsigned MOD_BITS   = 4;
  localparam int unsigned MOD_STAGES = HASH_W / MOD_BITS;

  localparam logic [HASH_W-1:0] MUR_C1    = 32'hcc9e2d51;
  localparam logic [HASH_W-1:0] MUR_C2    = 32'h1b873593;
  localparam logic [HASH_W-1:0] MUR_N     = 32'he6546b64;
  localparam logic [HASH_W-1:0] MUR_F1    = 32'h85ebca6b;
  localparam logic [HASH_W-1:0] MUR_F2    = 32'hc2b2ae35;
  localparam logic [HASH_W-1:0] KEY_BYTES = 32'd12;

  // Word passed from the hash pipeline to the remainder pipeline
  typedef struct packed {
    logic              valid;
    logic [HASH_W-1:0] hash;
    logic [DIV_W-1:0]  divisor;
    logic              no_route;
  } hop_word_t;

  function automatic logic [HASH_W-1:0] rotl(input logic [HASH_W-1:0] x,
                                             input int unsigned r);
    return (x << r) | (x >> (HASH_W - r));
  endfunction

  // h ^= k; h = rotl(h, 13); h = h * 5 + N  (the *5 is a shift and add)
  function automatic logic [HASH_W-1:0] mix_h(input logic [HASH_W-1:0] h,
                                              input logic [HASH_W-1:0] k);
    logic [HASH_W-1:0] x;
    x = rotl(h ^ k, 13);
    return (x << 2) + x + MUR_N;
  endfunction

endpackage

>>> hdl/ecmp_fhs_hash.sv
// ----------------------------------------------------------------------------
// ecmp_fhs_hash
// Seven-stage MurmurHash3 x86_32 pipeline over the 12-byte flow key, up to the
// second finaliser multiply. Hop count is saturated and carried alongside.
// ----------------------------------------------------------------------------
module ecmp_fhs_hash (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 advance_i,
  input  logic [ecmp_fhs_pkg::HASH_W-1:0]      seed_i,
  input  logic                                 valid_i,
  input  logic [ecmp_fhs_pkg::HASH_W-1:0]      src_addr_i,
  input  logic [ecmp_fhs_pkg::HASH_W-1:0]      dst_addr_i,
  input  logic [ecmp_fhs_pkg::PORT_W-1:0]      src_port_i,
  input  logic [ecmp_fhs_pkg::PORT_W-1:0]      dst_port_i,
  input  logic                                 ports_valid_i,
  input  logic [ecmp_fhs_pkg::HOP_CNT_W-1:0]   hop_count_i,
  output ecmp_fhs_pkg::hop_word_t              word_o
);

  localparam int unsigned NSTG = 7;

  logic [NSTG-1:0] valid_q;

  // per-stage payload
  logic [ecmp_fhs_pkg::HASH_W-1:0] k0_q, k1_q, k2_q;   // after C1 / C2
  logic [ecmp_fhs_pkg::HASH_W-1:0] h_q;                // running hash
  logic [ecmp_fhs_pkg::HASH_W-1:0] x_q;                // finaliser
  logic [ecmp_fhs_pkg::DIV_W-1:0]  div_q  [NSTG];
  logic                            nr_q   [NSTG];

  logic [ecmp_fhs_pkg::HASH_W-1:0] w2;
  logic [ecmp_fhs_pkg::DIV_W-1:0]  div_d;
  logic [ecmp_fhs_pkg::HASH_W-1:0] x6;

  assign w2 = ports_valid_i ? {dst_port_i, src_port_i} : '0;

  always_comb begin
    if (32'(hop_count_i) > 32'(ecmp_fhs_pkg::MAX_NEXT_HOPS)) begin
      div_d = ecmp_fhs_pkg::DIV_W'(ecmp_fhs_pkg::MAX_NEXT_HOPS);
    end else begin
      div_d = ecmp_fhs_pkg::DIV_W'(hop_count_i);
    end
  end

  assign x6 = x_q ^ (x_q >> 13);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (advance_i) begin
      valid_q <= {valid_q[NSTG-2:0], valid_i};
    end
  end

  // Stage 1..7 datapath. Key words are mixed ahead of the h chain.
  logic [ecmp_fhs_pkg::HASH_W-1:0] a0_q, a1_q, a2_q;   // stage 1 products
  logic [ecmp_fhs_pkg::HASH_W-1:0] b1_q, b2_q;         // kk words waiting on h
  logic [ecmp_fhs_pkg::HASH_W-1:0] hs4_q, hs5_q, c2_q, x7_q;

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      // S1
      a0_q     <= src_addr_i * ecmp_fhs_pkg::MUR_C1;
      a1_q     <= dst_addr_i * ecmp_fhs_pkg::MUR_C1;
      a2_q     <= w2 * ecmp_fhs_pkg::MUR_C1;
      div_q[0] <= div_d;
      nr_q[0]  <= (hop_count_i == '0);
      // S2
      k0_q <= ecmp_fhs_pkg::rotl(a0_q, 15) * ecmp_fhs_pkg::MUR_C2;
      k1_q <= ecmp_fhs_pkg::rotl(a1_q, 15) * ecmp_fhs_pkg::MUR_C2;
      k2_q <= ecmp_fhs_pkg::rotl(a2_q, 15) * ecmp_fhs_pkg::MUR_C2;
      // S3
      h_q  <= ecmp_fhs_pkg::mix_h(seed_i, k0_q);
      b1_q <= k1_q;
      b2_q <= k2_q;
      // S4 / S5
      hs4_q <= ecmp_fhs_pkg::mix_h(h_q, b1_q);
      c2_q  <= b2_q;
      hs5_q <= ecmp_fhs_pkg::mix_h(hs4_q, c2_q);
      // S6: length, first shift-xor and F1
      x_q  <= (hs5_q ^ ecmp_fhs_pkg::KEY_BYTES ^
               ((hs5_q ^ ecmp_fhs_pkg::KEY_BYTES) >> 16)) * ecmp_fhs_pkg::MUR_F1;
      // S7: second shift-xor and F2
      x7_q <= x6 * ecmp_fhs_pkg::MUR_F2;
      for (int s = 1; s < NSTG; s++) begin
        div_q[s] <= div_q[s-1];
        nr_q[s]  <= nr_q[s-1];
      end
    end
  end

  assign word_o.valid    = valid_q[NSTG-1];
  assign word_o.hash     = x7_q;
  assign word_o.divisor  = div_q[NSTG-1];
  assign word_o.no_route = nr_q[NSTG-1];

endmodule

>>> hdl/ecmp_fhs_mod.sv
// ----------------------------------------------------------------------------
// ecmp_fhs_mod
// Final hash xor-shift and a pipelined restoring remainder: four hash bits
// are retired per stage, giving hash modulo the hop count (saturated at 16).
// ----------------------------------------------------------------------------
module ecmp_fhs_mod (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 advance_i,
  input  ecmp_fhs_pkg::hop_word_t              word_i,
  output logic                                 valid_o,
  output logic [ecmp_fhs_pkg::HASH_W-1:0]      hash_value_o,
  output logic [ecmp_fhs_pkg::HOP_IDX_W-1:0]   hop_index_o,
  output logic                                 no_route_o
);

  localparam int unsigned NS = ecmp_fhs_pkg::MOD_STAGES;

  // remainder stays below the divisor, so one subtract per bit
  function automatic logic [ecmp_fhs_pkg::DIV_W-1:0] rem_step(
    input logic [ecmp_fhs_pkg::DIV_W-1:0]    r,
    input logic [ecmp_fhs_pkg::MOD_BITS-1:0] bits,
    input logic [ecmp_fhs_pkg::DIV_W-1:0]    n
  );
    logic [ecmp_fhs_pkg::DIV_W:0]   t;
    logic [ecmp_fhs_pkg::DIV_W-1:0] acc;
    acc = r;
    for (int i = ecmp_fhs_pkg::MOD_BITS - 1; i >= 0; i--) begin
      t = {acc, bits[i]};
      if (t >= {1'b0, n}) begin
        t = t - {1'b0, n};
      end
      acc = t[ecmp_fhs_pkg::DIV_W-1:0];
    end
    return acc;
  endfunction

  ecmp_fhs_pkg::hop_word_t          word_q [NS];
  logic [ecmp_fhs_pkg::DIV_W-1:0]   rem_q  [NS];
  logic [NS-1:0]                    valid_q;

  ecmp_fhs_pkg::hop_word_t          entry;

  // last finaliser step: h ^= h >> 16
  always_comb begin
    entry      = word_i;
    entry.hash = word_i.hash ^ (word_i.hash >> 16);
  end

  for (genvar s = 0; s < NS; s++) begin : g_stage
    ecmp_fhs_pkg::hop_word_t        w_in;
    logic [ecmp_fhs_pkg::DIV_W-1:0] r_in;
    logic                           v_in;

    if (s == 0) begin : g_first
      assign w_in = entry;
      assign r_in = '0;
      assign v_in = word_i.valid;
    end else begin : g_next
      assign w_in = word_q[s-1];
      assign r_in = rem_q[s-1];
      assign v_in = valid_q[s-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (advance_i) begin
        valid_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (advance_i) begin
        word_q[s] <= w_in;
        rem_q[s]  <= rem_step(r_in,
                              w_in.hash[ecmp_fhs_pkg::HASH_W-1-s*ecmp_fhs_pkg::MOD_BITS -:
                                        ecmp_fhs_pkg::MOD_BITS],
                              w_in.divisor);
      end
    end
  end

  assign valid_o      = valid_q[NS-1];
  assign hash_value_o = word_q[NS-1].hash;
  assign no_route_o   = word_q[NS-1].no_route;
  assign hop_index_o  = word_q[NS-1].no_route ? '0
                                              : ecmp_fhs_pkg::HOP_IDX_W'(rem_q[NS-1]);

endmodule

>>> hdl/ecmp_flow_hash_select_top.sv
// ----------------------------------------------------------------------------
// ecmp_flow_hash_select_top
// ECMP next hop selection: MurmurHash3 x86_32 of the flow key under a seed,
// then hash modulo the hop count (saturated at 16).
// ----------------------------------------------------------------------------
//  channel | handshake                 | payload
//  in      | in_valid_i / in_stall_o   | src_addr, dst_addr, src_port, dst_port,
//          |                           | ports_valid, hop_count
//  out     | out_valid_o / out_stall_i | hash_value, hop_index, no_route
//  cfg     | cfg_we_i                  | cfg_wdata_i (hash seed)
//
// One word per cycle while the output word is not stalled: 7 hash stages (one
// multiply each at most) and 8 remainder stages of 4 bits each.
// The last remainder stage is the output register.
// A stalled output word holds the whole pipeline; nothing is dropped.
// Reset clears the valid bits and the seed (seed 0).
// ----------------------------------------------------------------------------
module ecmp_flow_hash_select_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [ecmp_fhs_pkg::HASH_W-1:0]      cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [ecmp_fhs_pkg::HASH_W-1:0]      src_addr_i,
  input  logic [ecmp_fhs_pkg::HASH_W-1:0]      dst_addr_i,
  input  logic [ecmp_fhs_pkg::PORT_W-1:0]      src_port_i,
  input  logic [ecmp_fhs_pkg::PORT_W-1:0]      dst_port_i,
  input  logic                                 ports_valid_i,
  input  logic [ecmp_fhs_pkg::HOP_CNT_W-1:0]   hop_count_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [ecmp_fhs_pkg::HASH_W-1:0]      hash_value_o,
  output logic [ecmp_fhs_pkg::HOP_IDX_W-1:0]   hop_index_o,
  output logic                                 no_route_o
);

  logic [ecmp_fhs_pkg::HASH_W-1:0] seed_q;
  logic                            advance;
  ecmp_fhs_pkg::hop_word_t         hash_word;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
    end else if (cfg_we_i) begin
      seed_q <= cfg_wdata_i;
    end
  end

  // whole pipeline moves unless the output word is held
  assign advance    = !(out_valid_o && out_stall_i);
  assign in_stall_o = !advance;

  ecmp_fhs_hash u_hash (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .advance_i     (advance),
    .seed_i        (seed_q),
    .valid_i       (in_valid_i),
    .src_addr_i    (src_addr_i),
    .dst_addr_i    (dst_addr_i),
    .src_port_i    (src_port_i),
    .dst_port_i    (dst_port_i),
    .ports_valid_i (ports_valid_i),
    .hop_count_i   (hop_count_i),
    .word_o        (hash_word)
  );

  ecmp_fhs_mod u_mod (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .advance_i    (advance),
    .word_i       (hash_word),
    .valid_o      (out_valid_o),
    .hash_value_o (hash_value_o),
    .hop_index_o  (hop_index_o),
    .no_route_o   (no_route_o)
  );

endmodule

>>> hdl/ecmp_fhs_chk.sv
// ----------------------------------------------------------------------------
// ecmp_fhs_chk
// Port-level checks for the ECMP flow hash select, bound to the top level.
// ----------------------------------------------------------------------------
module ecmp_fhs_chk (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_stall_o,
  input  logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  input  logic [ecmp_fhs_pkg::HASH_W-1:0]      hash_value_o,
  input  logic [ecmp_fhs_pkg::HOP_IDX_W-1:0]   hop_index_o,
  input  logic                                 no_route_o
);

  // input side only backs up when a result word is being held
  a_stall_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("in_stall_o does not follow the held output word");

  a_no_route_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && no_route_o) |-> (hop_index_o == '0))
    else $error("hop index non-zero on a no-route word");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("stalled output word withdrawn");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      ($stable(hash_value_o) && $stable(hop_index_o) && $stable(no_route_o)))
    else $error("stalled output word changed");

endmodule

bind ecmp_flow_hash_select_top ecmp_fhs_chk u_ecmp_fhs_chk (.*);
